// ----- src/fbci_pkg.sv -----
// Package for the fault blink code indicator: beat payload types,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbci_pkg;

  // Input beat: one tick of motor status.
  typedef struct packed {
    logic       motor_running;
    logic [3:0] fault_code;
  } in_beat_t;

  // Output beat: pin levels after the tick.
  typedef struct packed {
    logic led_level;
    logic fg_level;
  } out_beat_t;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] RegIdleToggleTicks   = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegSlotPrescaleLimit = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegPauseSlots        = 2'd2;

  localparam int unsigned CfgDataWidth = 8;

  // Register reset values.
  localparam logic [7:0] IdleToggleTicksReset   = 8'd50;
  localparam logic [7:0] SlotPrescaleLimitReset = 8'd20;
  localparam logic [7:0] PauseSlotsReset        = 8'd10;

  // Highest fault code that reloads the pulse count.
  localparam logic [3:0] MaxPulseCode = 4'd12;

endpackage

`default_nettype wire

// ----- src/fault_blink_code_indicator_unit.sv -----
// Top level of the fault blink code indicator: tick state machine and
// output register. Depends on fbci_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is one tick and produces exactly one output beat with the
// LED and FG levels after that tick. The block takes one beat per clock while
// the output side is ready: the counters update in the cycle a beat is
// accepted and the result lands in a single output register, which is
// refilled in the same cycle it is taken, so throughput is one beat per
// cycle. Fault codes 1 to 12 blink that many pulses per train,
// codes 13 to 15 repeat the last valid count, and a prescale limit of 255
// never lets a blink slot fire. Configuration writes take effect on the next
// clock edge and should be made while no beats are in flight.
module fault_blink_code_indicator_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  fbci_pkg::in_beat_t             in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output fbci_pkg::out_beat_t                  out_data,
  input  wire                                  cfg_wr_en,
  input  wire  [fbci_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  wire  [fbci_pkg::CfgDataWidth-1:0]    cfg_data
);

  // Configuration registers.
  logic [7:0] idle_toggle_ticks;
  logic [7:0] slot_prescale_limit;
  logic [7:0] pause_slots;

  // Tick state.
  logic [7:0] idle_counter,   idle_counter_next;
  logic [7:0] slot_prescaler, slot_prescaler_next;
  logic [4:0] toggle_target,  toggle_target_next;
  logic [7:0] slot_counter,   slot_counter_next;
  logic       pause_phase,    pause_phase_next;
  logic       led_state,      led_state_next;
  logic       fg_state,       fg_state_next;

  logic in_accept;
  logic code_valid;
  logic slot_fire;
  logic [7:0] presc_inc;
  logic [7:0] slot_inc;
  logic [7:0] idle_inc;

  // The output register frees up in the same cycle its beat is taken.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_toggle_ticks   <= fbci_pkg::IdleToggleTicksReset;
      slot_prescale_limit <= fbci_pkg::SlotPrescaleLimitReset;
      pause_slots         <= fbci_pkg::PauseSlotsReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fbci_pkg::RegIdleToggleTicks:   idle_toggle_ticks   <= cfg_data;
        fbci_pkg::RegSlotPrescaleLimit: slot_prescale_limit <= cfg_data;
        fbci_pkg::RegPauseSlots:        pause_slots         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign presc_inc  = slot_prescaler + 8'd1;
  assign slot_inc   = slot_counter + 8'd1;
  assign idle_inc   = idle_counter + 8'd1;
  assign slot_fire  = presc_inc > slot_prescale_limit;
  assign code_valid = (in_data.fault_code != 4'd0) &&
                      (in_data.fault_code <= fbci_pkg::MaxPulseCode);

  // Next tick state from the current beat.
  always_comb begin
    idle_counter_next   = idle_counter;
    slot_prescaler_next = slot_prescaler;
    toggle_target_next  = toggle_target;
    slot_counter_next   = slot_counter;
    pause_phase_next    = pause_phase;
    led_state_next      = led_state;
    fg_state_next       = fg_state;

    if (in_data.fault_code != 4'd0) begin
      // Fault: the prescaler paces the blink slots.
      slot_prescaler_next = slot_fire ? 8'd0 : presc_inc;
      if (slot_fire) begin
        if (code_valid) begin
          toggle_target_next = {in_data.fault_code, 1'b0};
        end
        if (!pause_phase) begin
          led_state_next = !led_state;
          fg_state_next  = !fg_state;
          if (slot_inc >= {3'd0, toggle_target_next}) begin
            slot_counter_next = 8'd0;
            pause_phase_next  = 1'b1;
          end else begin
            slot_counter_next = slot_inc;
          end
        end else begin
          led_state_next = 1'b0;
          fg_state_next  = 1'b1;
          if (slot_inc >= pause_slots) begin
            slot_counter_next = 8'd0;
            pause_phase_next  = 1'b0;
          end else begin
            slot_counter_next = slot_inc;
          end
        end
      end
    end else if (!in_data.motor_running) begin
      // Stopped without fault: slow idle blink, FG low.
      if (idle_inc >= idle_toggle_ticks) begin
        idle_counter_next = 8'd0;
        led_state_next    = !led_state;
      end else begin
        idle_counter_next = idle_inc;
      end
      fg_state_next = 1'b0;
    end else begin
      // Running without fault: LED steady on.
      led_state_next = 1'b1;
    end
  end

  // Tick state registers advance once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_counter   <= 8'd0;
      slot_prescaler <= 8'd0;
      toggle_target  <= 5'd0;
      slot_counter   <= 8'd0;
      pause_phase    <= 1'b0;
      led_state      <= 1'b0;
      fg_state       <= 1'b0;
    end else if (in_accept) begin
      idle_counter   <= idle_counter_next;
      slot_prescaler <= slot_prescaler_next;
      toggle_target  <= toggle_target_next;
      slot_counter   <= slot_counter_next;
      pause_phase    <= pause_phase_next;
      led_state      <= led_state_next;
      fg_state       <= fg_state_next;
    end
  end

  // Output register holding the result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data.led_level <= led_state_next;
      out_data.fg_level  <= fg_state_next;
    end
  end

endmodule

`default_nettype wire
